// ===== src/abrf_pkg.sv =====
package abrf_pkg;

    // Value format: signed fixed point, VALUE_BITS wide
    localparam int VALUE_BITS   = 32;
    localparam int PROD_BITS    = 2 * VALUE_BITS;
    localparam int TOL_BITS     = 31;
    localparam int CNT_BITS     = 16;
    localparam int REG_IDX_BITS = 1;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

    // Configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_TOLERANCE = 1'b0,
        REG_MAX_ITER  = 1'b1
    } t_reg_idx;

    // Result status codes
    typedef enum logic [2:0] {
        RES_EVAL          = 3'd0,
        RES_ROOT          = 3'd1,
        RES_NOT_BRACKETED = 3'd2,
        RES_NO_CONV       = 3'd3,
        RES_IGNORED       = 3'd4
    } t_status;

    // Search phase: what the last requested point was
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_GUESS = 2'd3
    } t_phase;

    // Controller states
    typedef enum logic [2:0] {
        S_WAIT_IN  = 3'd0,
        S_EXEC     = 3'd1,
        S_PLAN     = 3'd2,
        S_DIV_GO   = 3'd3,
        S_DIV_WAIT = 3'd4,
        S_EMIT     = 3'd5
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic mul;
        logic div_go;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic need_guess;
        logic use_fp;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== src/abrf_intf.sv =====
// Input item channel
interface abrf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic signed [abrf_pkg::VALUE_BITS-1:0] bound_a;
    logic signed [abrf_pkg::VALUE_BITS-1:0] bound_b;
    logic signed [abrf_pkg::VALUE_BITS-1:0] func_value;

    modport source (output valid, output kind, output bound_a, output bound_b,
                    output func_value, input ready);
    modport sink   (input valid, input kind, input bound_a, input bound_b,
                    input func_value, output ready);
endinterface

// Result channel
interface abrf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            status;
    logic signed [abrf_pkg::VALUE_BITS-1:0] point;
    logic [abrf_pkg::CNT_BITS-1:0]         guesses_used;

    modport source (output valid, output status, output point, output guesses_used,
                    input ready);
    modport sink   (input valid, input status, input point, input guesses_used,
                    output ready);
endinterface

// Configuration write channel
interface abrf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [abrf_pkg::REG_IDX_BITS-1:0]   index;
    logic [abrf_pkg::TOL_BITS-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/abrf_div.sv =====
module abrf_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [abrf_pkg::PROD_BITS-1:0]     i_num,
    input  logic [abrf_pkg::VALUE_BITS-1:0]    i_den,
    output logic                               o_done,
    output logic [abrf_pkg::PROD_BITS-1:0]     o_quot
);

    localparam int VB = abrf_pkg::VALUE_BITS;
    localparam int PB = abrf_pkg::PROD_BITS;
    localparam int CB = abrf_pkg::DIV_CNT_BITS;

    logic [CB-1:0] r_cnt;
    logic          r_done;
    logic [PB-1:0] r_nq;   // numerator shifts out, quotient shifts in
    logic [VB-1:0] r_rem;
    logic [VB-1:0] r_den;

    logic [VB:0]   rem_sh;
    logic [VB+1:0] trial;

    // One restoring step: shift in next numerator bit, try subtract
    always_comb begin
        rem_sh = {r_rem, r_nq[PB-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_den};
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CB'(PB);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (!trial[VB+1]) begin
                r_rem <= trial[VB-1:0];
                r_nq  <= {r_nq[PB-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[VB-1:0];
                r_nq  <= {r_nq[PB-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

// ===== src/abrf_ctrl.sv =====
module abrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  abrf_pkg::t_stat   i_stat,
    output abrf_pkg::t_cmd    o_cmd
);

    abrf_pkg::t_state r_state;
    abrf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abrf_pkg::S_WAIT_IN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            abrf_pkg::S_WAIT_IN: begin
                o_cmd.take = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = abrf_pkg::S_EXEC;
                end
            end
            abrf_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = abrf_pkg::S_PLAN;
            end
            abrf_pkg::S_PLAN: begin
                // false-position guess goes through multiply and divide
                if (i_stat.need_guess && i_stat.use_fp) begin
                    o_cmd.mul = 1'b1;
                    n_state   = abrf_pkg::S_DIV_GO;
                end else begin
                    n_state   = abrf_pkg::S_EMIT;
                end
            end
            abrf_pkg::S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = abrf_pkg::S_DIV_WAIT;
            end
            abrf_pkg::S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = abrf_pkg::S_EMIT;
                end
            end
            abrf_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = abrf_pkg::S_WAIT_IN;
                end
            end
            default: begin
                n_state = abrf_pkg::S_WAIT_IN;
            end
        endcase
    end

endmodule

// ===== src/abrf_dp.sv =====
module abrf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  abrf_pkg::t_cmd    i_cmd,
    output abrf_pkg::t_stat   o_stat,
    abrf_in_if.sink           i_in,
    abrf_cfg_if.sink          i_cfg,
    abrf_out_if.source        o_out
);

    localparam int VB = abrf_pkg::VALUE_BITS;
    localparam int PB = abrf_pkg::PROD_BITS;
    localparam int CN = abrf_pkg::CNT_BITS;
    localparam int TB = abrf_pkg::TOL_BITS;

    // Configuration
    logic [TB-1:0] r_tol;
    logic [CN-1:0] r_max;

    // Captured input beat
    logic                 r_kind;
    logic signed [VB-1:0] r_a;
    logic signed [VB-1:0] r_b;
    logic signed [VB-1:0] r_v;

    // Search state
    logic signed [VB-1:0] r_low,  n_low;
    logic signed [VB-1:0] r_high, n_high;
    logic signed [VB-1:0] r_vlow, n_vlow;
    logic signed [VB-1:0] r_vhigh, n_vhigh;
    logic signed [VB-1:0] r_guess;
    logic                 r_fpn, n_fpn;
    logic [CN-1:0]        r_cnt, n_cnt;
    abrf_pkg::t_phase     r_phase, n_phase;

    // Pending result
    abrf_pkg::t_status    r_res_status, n_res_status;
    logic signed [VB-1:0] r_res_point, n_res_point;
    logic                 r_need_guess, n_need_guess;

    // False-position operands
    logic [PB-1:0] r_prod;
    logic [VB-1:0] r_dmag;
    logic          r_dz;
    logic          r_sneg;

    // Output register
    logic                 r_ovalid;
    abrf_pkg::t_status    r_ostatus;
    logic signed [VB-1:0] r_opoint;
    logic [CN-1:0]        r_ocount;

    logic                 v_root;
    logic                 low_root;
    logic                 high_root;
    logic [VB:0]          span_x;
    logic [VB-1:0]        span;
    logic [VB:0]          diff_x;
    logic [VB-1:0]        mag_vh;
    logic [VB:0]          mid_x;
    logic signed [VB-1:0] mid;
    logic [PB-1:0]        quot;
    logic                 div_done;
    logic signed [VB-1:0] fp_guess;
    logic signed [VB-1:0] new_guess;
    logic                 out_free;

    function automatic logic [VB-1:0] f_mag(input logic signed [VB-1:0] v);
        f_mag = v[VB-1] ? (~v + 1'b1) : v;
    endfunction

    assign i_in.ready  = i_cmd.take;
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_ovalid || o_out.ready;

    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.need_guess = r_need_guess;
    assign o_stat.use_fp     = r_fpn;
    assign o_stat.div_done   = div_done;
    assign o_stat.out_free   = out_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TB'(66);
            r_max <= CN'(100);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                abrf_pkg::REG_TOLERANCE: r_tol <= i_cfg.data;
                abrf_pkg::REG_MAX_ITER:  r_max <= i_cfg.data[CN-1:0];
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in.valid) begin
            r_kind <= i_in.kind;
            r_a    <= i_in.bound_a;
            r_b    <= i_in.bound_b;
            r_v    <= i_in.func_value;
        end
    end

    // Root tests against tolerance
    always_comb begin
        v_root    = f_mag(r_v)    < {1'b0, r_tol};
        low_root  = f_mag(r_vlow) < {1'b0, r_tol};
        high_root = f_mag(r_v)    < {1'b0, r_tol};
    end

    // Item evaluation: bracket update and result selection
    always_comb begin
        n_low        = r_low;
        n_high       = r_high;
        n_vlow       = r_vlow;
        n_vhigh      = r_vhigh;
        n_fpn        = r_fpn;
        n_cnt        = r_cnt;
        n_phase      = r_phase;
        n_res_status = abrf_pkg::RES_IGNORED;
        n_res_point  = '0;
        n_need_guess = 1'b0;
        if (!r_kind) begin
            // start: order the ends and ask for f(low)
            if (r_a > r_b) begin
                n_low  = r_b;
                n_high = r_a;
            end else begin
                n_low  = r_a;
                n_high = r_b;
            end
            n_cnt        = '0;
            n_fpn        = 1'b0;
            n_phase      = abrf_pkg::PH_LOW;
            n_res_status = abrf_pkg::RES_EVAL;
            n_res_point  = n_low;
        end else begin
            case (r_phase)
                abrf_pkg::PH_LOW: begin
                    n_vlow       = r_v;
                    n_phase      = abrf_pkg::PH_HIGH;
                    n_res_status = abrf_pkg::RES_EVAL;
                    n_res_point  = r_high;
                end
                abrf_pkg::PH_HIGH: begin
                    n_vhigh = r_v;
                    n_phase = abrf_pkg::PH_IDLE;
                    if ((r_vlow != '0) && (r_v != '0) && (r_vlow[VB-1] == r_v[VB-1])) begin
                        n_res_status = abrf_pkg::RES_NOT_BRACKETED;
                    end else if (low_root) begin
                        n_res_status = abrf_pkg::RES_ROOT;
                        n_res_point  = r_low;
                    end else if (high_root) begin
                        n_res_status = abrf_pkg::RES_ROOT;
                        n_res_point  = r_high;
                    end else if (r_cnt >= r_max) begin
                        n_res_status = abrf_pkg::RES_NO_CONV;
                    end else begin
                        n_phase      = abrf_pkg::PH_GUESS;
                        n_res_status = abrf_pkg::RES_EVAL;
                        n_need_guess = 1'b1;
                    end
                end
                abrf_pkg::PH_GUESS: begin
                    n_cnt = r_cnt + 1'b1;
                    if (v_root) begin
                        n_phase      = abrf_pkg::PH_IDLE;
                        n_res_status = abrf_pkg::RES_ROOT;
                        n_res_point  = r_guess;
                    end else begin
                        // sign change against f(low) moves the high end
                        if ((r_v != '0) && (r_vlow != '0) && (r_v[VB-1] != r_vlow[VB-1])) begin
                            n_high  = r_guess;
                            n_vhigh = r_v;
                        end else begin
                            n_low  = r_guess;
                            n_vlow = r_v;
                        end
                        n_fpn = !r_fpn;
                        if (n_cnt >= r_max) begin
                            n_phase      = abrf_pkg::PH_IDLE;
                            n_res_status = abrf_pkg::RES_NO_CONV;
                        end else begin
                            n_res_status = abrf_pkg::RES_EVAL;
                            n_need_guess = 1'b1;
                        end
                    end
                end
                default: begin
                    n_res_status = abrf_pkg::RES_IGNORED;
                end
            endcase
        end
    end

    // Search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= '0;
            r_high       <= '0;
            r_vlow       <= '0;
            r_vhigh      <= '0;
            r_fpn        <= 1'b0;
            r_cnt        <= '0;
            r_phase      <= abrf_pkg::PH_IDLE;
            r_need_guess <= 1'b0;
        end else if (i_cmd.exec) begin
            r_low        <= n_low;
            r_high       <= n_high;
            r_vlow       <= n_vlow;
            r_vhigh      <= n_vhigh;
            r_fpn        <= n_fpn;
            r_cnt        <= n_cnt;
            r_phase      <= n_phase;
            r_need_guess <= n_need_guess;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
            r_res_point  <= n_res_point;
        end
    end

    // Span, value difference and midpoint
    always_comb begin
        span_x = {r_high[VB-1], r_high} - {r_low[VB-1], r_low};
        span   = span_x[VB-1:0];
        diff_x = {r_vhigh[VB-1], r_vhigh} - {r_vlow[VB-1], r_vlow};
        mag_vh = f_mag(r_vhigh);
        mid_x  = {r_low[VB-1], r_low} + {2'b00, span[VB-1:1]};
        mid    = mid_x[VB-1:0];
    end

    // False-position numerator product and divisor
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PB'(mag_vh) * PB'(span);
            r_dmag <= diff_x[VB] ? VB'(~diff_x + 1'b1) : diff_x[VB-1:0];
            r_dz   <= (diff_x == '0);
            r_sneg <= (!r_vhigh[VB-1] && (r_vhigh != '0) && diff_x[VB]) ||
                      (r_vhigh[VB-1] && !diff_x[VB] && (diff_x != '0));
        end
    end

    abrf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (r_prod),
        .i_den   (r_dmag),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Guess selection; false position falls back to the midpoint
    always_comb begin
        if (r_dz) begin
            fp_guess = mid;
        end else if (quot == '0) begin
            fp_guess = r_high;
        end else if (r_sneg || (quot[PB-1:VB] != '0) || (quot[VB-1:0] > span)) begin
            fp_guess = mid;
        end else begin
            fp_guess = r_high - quot[VB-1:0];
        end
        new_guess = r_fpn ? fp_guess : mid;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && r_need_guess) begin
            r_guess <= new_guess;
        end
    end

    // Output register: result beat waits here for the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ostatus <= r_res_status;
            r_opoint  <= r_need_guess ? new_guess : r_res_point;
            r_ocount  <= r_cnt;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ostatus;
    assign o_out.point        = r_opoint;
    assign o_out.guesses_used = r_ocount;

`ifndef SYNTHESIS
    // Bracket stays ordered
    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_high)
        else $error("bracket ends out of order");

    // A pending guess lies inside the bracket
    a_guess_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && (r_phase == abrf_pkg::PH_GUESS)) |->
        ((r_guess >= r_low) && (r_guess <= r_high)))
        else $error("guess outside bracket");

    // A result is loaded only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || o_out.ready))
        else $error("result overwrites waiting beat");

    // Divider is started only after a multiply was issued
    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |-> $past(i_cmd.mul))
        else $error("divide started without product");
`endif

endmodule

// ===== src/alternating_bracket_root_finder_core.sv =====
// Channel   Dir  Beat content
// i_in      in   kind, bound_a, bound_b, func_value
// o_out     out  status, point, guesses_used
// i_cfg     in   index (0 tolerance, 1 max_iterations), data
//
// An input beat goes through exec and plan to emit; a false-position guess adds
// a multiply and a restoring divide of the 64-bit product between plan and emit.
// One item is worked at a time; the next input beat is taken once the result
// sits in the output register, even while that beat still waits for o_out.ready.
// i_rst_n is synchronous and active low; it restores tolerance 66 and
// max_iterations 100 and leaves the search idle. Configuration beats are always taken.
module alternating_bracket_root_finder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    abrf_in_if.sink      i_in,
    abrf_cfg_if.sink     i_cfg,
    abrf_out_if.source   o_out
);

    abrf_pkg::t_cmd  cmd;
    abrf_pkg::t_stat stat;

    // Sequencer
    abrf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Bracket state, arithmetic and output register
    abrf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule

// ===== sim/alternating_bracket_root_finder_core_tb.sv =====
`timescale 1ns / 100ps

module alternating_bracket_root_finder_core_tb;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // One result beat as the block should produce it
    typedef struct packed {
        abrf_pkg::t_status status;
        logic [31:0]       point;
        logic [15:0]       guesses;
    } t_result;

    // Directed row: either a register write or an input beat
    typedef struct packed {
        logic               is_cfg;
        abrf_pkg::t_reg_idx reg_sel;
        logic [30:0]        reg_val;
        logic               kind;
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        fv;
        logic               typed;
        abrf_pkg::t_status  st;
        logic [31:0]        pt;
        logic [15:0]        gu;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    abrf_in_if  in_ch ();
    abrf_out_if out_ch ();
    abrf_cfg_if cfg_ch ();

    alternating_bracket_root_finder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Search model state and register copies
    longint            lo_x, hi_x, f_lo, f_hi, probe_x;
    bit                fp_turn;
    bit [15:0]         probes_done;
    abrf_pkg::t_phase  search_ph;
    bit [30:0]         tol_q;
    bit [15:0]         iter_cap;

    // Outside function that the stimulus answers with
    longint      fn_root;
    int          fn_shape, fn_shift, fn_gain;
    bit          fn_neg;

    t_result     due_answers[$];
    t_dir_row    dir_tab[$];
    t_result     want;
    logic [31:0] last_point;
    int unsigned src_pct, snk_pct;
    int unsigned faults, checked, beats_in;
    int unsigned tally[5];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[alternating_bracket_root_finder_core] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Search model
    // ---------------------------------------------------------------
    function automatic bit [63:0] magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int sgn_of(longint v);
        if (v > 0) return 1;
        if (v < 0) return -1;
        return 0;
    endfunction

    function automatic bit below_tol(longint v);
        return magn(v) < {33'b0, tol_q};
    endfunction

    function automatic longint mid_x();
        return lo_x + ((hi_x - lo_x) >>> 1);
    endfunction

    // secant through the bracket ends; falls back to the midpoint
    function automatic longint false_pos_x();
        bit [63:0] span_u, dmag, num, q;
        int        dsign;
        span_u = hi_x - lo_x;
        if (f_hi >= f_lo) begin
            dmag  = f_hi - f_lo;
            dsign = 1;
        end else begin
            dmag  = f_lo - f_hi;
            dsign = -1;
        end
        if (dmag == 0) return mid_x();
        num = magn(f_hi) * span_u;
        q   = num / dmag;
        if (q == 0) return hi_x;
        if (sgn_of(f_hi) * dsign < 0 || q > span_u) return mid_x();
        return hi_x - longint'(q);
    endfunction

    function automatic t_result answer(abrf_pkg::t_status s, longint p);
        t_result r;
        r.status  = s;
        r.point   = p[31:0];
        r.guesses = probes_done;
        return r;
    endfunction

    function automatic t_result bracket_step(logic kind, logic signed [31:0] a,
                                             logic signed [31:0] b,
                                             logic signed [31:0] fv);
        longint v, ax, bx;
        ax = longint'(a);
        bx = longint'(b);
        v  = longint'(fv);
        if (kind == KIND_START) begin
            lo_x        = (ax > bx) ? bx : ax;
            hi_x        = (ax > bx) ? ax : bx;
            probes_done = '0;
            fp_turn     = 1'b0;
            search_ph   = abrf_pkg::PH_LOW;
            return answer(abrf_pkg::RES_EVAL, lo_x);
        end
        case (search_ph)
            abrf_pkg::PH_LOW: begin
                f_lo      = v;
                search_ph = abrf_pkg::PH_HIGH;
                return answer(abrf_pkg::RES_EVAL, hi_x);
            end
            abrf_pkg::PH_HIGH: begin
                f_hi      = v;
                search_ph = abrf_pkg::PH_IDLE;
                if (sgn_of(f_lo) * sgn_of(f_hi) > 0)
                    return answer(abrf_pkg::RES_NOT_BRACKETED, 64'sd0);
                if (below_tol(f_lo)) return answer(abrf_pkg::RES_ROOT, lo_x);
                if (below_tol(f_hi)) return answer(abrf_pkg::RES_ROOT, hi_x);
                if (probes_done >= iter_cap) return answer(abrf_pkg::RES_NO_CONV, 64'sd0);
                probe_x   = fp_turn ? false_pos_x() : mid_x();
                search_ph = abrf_pkg::PH_GUESS;
                return answer(abrf_pkg::RES_EVAL, probe_x);
            end
            abrf_pkg::PH_GUESS: begin
                probes_done = probes_done + 16'd1;
                if (below_tol(v)) begin
                    search_ph = abrf_pkg::PH_IDLE;
                    return answer(abrf_pkg::RES_ROOT, probe_x);
                end
                // keep the end whose sign differs from the new value
                if (sgn_of(v) * sgn_of(f_lo) < 0) begin
                    hi_x = probe_x;
                    f_hi = v;
                end else begin
                    lo_x = probe_x;
                    f_lo = v;
                end
                fp_turn = ~fp_turn;
                if (probes_done >= iter_cap) begin
                    search_ph = abrf_pkg::PH_IDLE;
                    return answer(abrf_pkg::RES_NO_CONV, 64'sd0);
                end
                probe_x = fp_turn ? false_pos_x() : mid_x();
                return answer(abrf_pkg::RES_EVAL, probe_x);
            end
            default: return answer(abrf_pkg::RES_IGNORED, 64'sd0);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Outside function used to answer point requests
    // ---------------------------------------------------------------
    function automatic logic [31:0] fn_eval(logic signed [31:0] x);
        longint d, y, q;
        d = longint'(x) - fn_root;
        case (fn_shape)
            0: y = d >>> fn_shift;
            1: y = d * longint'(fn_gain);
            2: y = (d < 0) ? longint'(-1000 * fn_gain) :
                             ((d == 0) ? 64'sd0 : longint'(1000 * fn_gain));
            default: begin
                q = d >>> 12;
                y = q * q;
                if (d < 0) y = -y;
            end
        endcase
        if (fn_neg) y = -y;
        if (y > 64'sd2147483647) y = 64'sd2147483647;
        if (y < -64'sd2147483648) y = -64'sd2147483648;
        return y[31:0];
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'h1;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_bounds(output logic [31:0] a, output logic [31:0] b);
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                a = $urandom;
                b = $urandom;
            end
            1: begin
                a = c - $urandom_range(0, 2000);
                b = c + $urandom_range(0, 2000);
            end
            2: begin
                a = pick_edge();
                b = pick_edge();
            end
            default: begin
                a = c;
                b = ($urandom_range(0, 1) != 0) ? c : c + $urandom_range(1, 4);
            end
        endcase
    endtask

    task automatic pick_function(logic signed [31:0] a, logic signed [31:0] b);
        longint    lo, hi;
        bit [63:0] span_w;
        lo       = (a > b) ? longint'(b) : longint'(a);
        hi       = (a > b) ? longint'(a) : longint'(b);
        span_w   = hi - lo + 64'sd1;
        fn_shape = $urandom_range(0, 3);
        fn_shift = $urandom_range(0, 10);
        fn_gain  = $urandom_range(1, 8);
        fn_neg   = ($urandom_range(0, 1) != 0);
        if ($urandom_range(99) < 75)
            fn_root = lo + longint'({$urandom, $urandom} % span_w);
        else
            fn_root = longint'($signed($urandom));
    endtask

    // ---------------------------------------------------------------
    // Channel drivers
    // ---------------------------------------------------------------
    task automatic send_item(logic kind, logic [31:0] a, logic [31:0] b,
                             logic [31:0] fv, output abrf_pkg::t_status st);
        t_result r;
        cfg_ch.valid <= 1'b0;
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.bound_a    <= a;
        in_ch.bound_b    <= b;
        in_ch.func_value <= fv;
        do @(posedge i_clk); while (!in_ch.ready);
        r = bracket_step(kind, a, b, fv);
        due_answers.push_back(r);
        last_point = r.point;
        st         = r.status;
        beats_in++;
    endtask

    // register writes wait until the block has delivered everything
    task automatic cfg_write(abrf_pkg::t_reg_idx idx, logic [30:0] val);
        in_ch.valid <= 1'b0;
        while (due_answers.size() != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == abrf_pkg::REG_TOLERANCE)
            tol_q = val;
        else
            iter_cap = val[15:0];
    endtask

    // ---------------------------------------------------------------
    // Directed table rows
    // ---------------------------------------------------------------
    function automatic t_dir_row cfg_row(abrf_pkg::t_reg_idx idx, logic [30:0] val);
        t_dir_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_dir_row start_row(logic [31:0] a, logic [31:0] b);
        t_dir_row r;
        r      = '0;
        r.kind = KIND_START;
        r.a    = a;
        r.b    = b;
        r.fv   = $urandom;
        return r;
    endfunction

    function automatic t_dir_row value_row(logic [31:0] fv);
        t_dir_row r;
        r      = '0;
        r.kind = KIND_VALUE;
        r.a    = $urandom;
        r.b    = $urandom;
        r.fv   = fv;
        return r;
    endfunction

    function automatic t_dir_row with_expect(t_dir_row r, abrf_pkg::t_status s,
                                             logic [31:0] p, logic [15:0] g);
        r.typed = 1'b1;
        r.st    = s;
        r.pt    = p;
        r.gu    = g;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random search sequences
    // ---------------------------------------------------------------
    task automatic random_phase(int unsigned n_target);
        int unsigned       done, cap, resp, pick;
        abrf_pkg::t_status st;
        logic [31:0]       ba, bb, fv;
        done = 0;
        while (done < n_target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // stray reports, mostly while idle
                repeat ($urandom_range(1, 3)) begin
                    send_item(KIND_VALUE, $urandom, $urandom, $urandom, st);
                    if (st != abrf_pkg::RES_IGNORED) done++;
                end
            end else begin
                pick_bounds(ba, bb);
                pick_function(ba, bb);
                send_item(KIND_START, ba, bb, $urandom, st);
                done++;
                // short broken runs get noise; full runs follow the function
                cap  = (pick < 20) ? $urandom_range(0, 3) : $urandom_range(8, 130);
                resp = 0;
                while (search_ph != abrf_pkg::PH_IDLE && resp < cap) begin
                    if (pick < 20 || $urandom_range(99) < 4)
                        fv = $urandom;
                    else
                        fv = fn_eval(last_point);
                    send_item(KIND_VALUE, $urandom, $urandom, fv, st);
                    resp++;
                    if (st != abrf_pkg::RES_IGNORED) done++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            checked++;
            if (due_answers.size() == 0) begin
                if (faults < 10)
                    $display("%0t: unexpected result status %0d point %h guesses %0d",
                             $time, out_ch.status, out_ch.point, out_ch.guesses_used);
                faults++;
            end else begin
                want = due_answers.pop_front();
                tally[int'(want.status)]++;
                if (out_ch.status !== want.status || out_ch.point !== want.point ||
                    out_ch.guesses_used !== want.guesses) begin
                    if (faults < 10)
                        $display({"%0t: mismatch, expected status %0d point %h guesses %0d,",
                                  " got status %0d point %h guesses %0d"},
                                 $time, want.status, want.point, want.guesses,
                                 out_ch.status, out_ch.point, out_ch.guesses_used);
                    faults++;
                end
            end
        end
        out_ch.ready <= (snk_pct == 0) || ($urandom_range(99) >= snk_pct);
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int                ph;
        logic [30:0]       tol_w;
        logic [15:0]       max_w;
        abrf_pkg::t_status st;
        t_result           typed;

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_START;
        in_ch.bound_a    <= '0;
        in_ch.bound_b    <= '0;
        in_ch.func_value <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= abrf_pkg::REG_TOLERANCE;
        cfg_ch.data      <= '0;
        src_pct          = 0;
        snk_pct          = 0;
        faults           = 0;
        checked          = 0;
        beats_in         = 0;
        foreach (tally[i]) tally[i] = 0;

        // model starts from the reset state
        tol_q       = 31'd66;
        iter_cap    = 16'd100;
        lo_x        = '0;
        hi_x        = '0;
        f_lo        = '0;
        f_hi        = '0;
        probe_x     = '0;
        fp_turn     = 1'b0;
        probes_done = '0;
        search_ph   = abrf_pkg::PH_IDLE;
        last_point  = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab = '{
            // report while idle right after reset
            with_expect(value_row(32'd7), abrf_pkg::RES_IGNORED, 32'h0, 16'd0),
            // full-range bracket given in reverse order
            with_expect(start_row(32'h7fff_ffff, 32'h8000_0000), abrf_pkg::RES_EVAL,
                        32'h8000_0000, 16'd0),
            with_expect(value_row(32'h8000_0000), abrf_pkg::RES_EVAL, 32'h7fff_ffff,
                        16'd0),
            with_expect(value_row(32'h7fff_ffff), abrf_pkg::RES_EVAL, 32'hffff_ffff,
                        16'd0),
            value_row(32'h7fff_ffff),
            // same sign at both ends, both of them small
            with_expect(start_row(32'd200, 32'd100), abrf_pkg::RES_EVAL, 32'd100, 16'd0),
            with_expect(value_row(32'd3), abrf_pkg::RES_EVAL, 32'd200, 16'd0),
            with_expect(value_row(32'd9), abrf_pkg::RES_NOT_BRACKETED, 32'h0, 16'd0),
            // root at the low end
            with_expect(start_row(-32'sd50, 32'd50), abrf_pkg::RES_EVAL, -32'sd50, 16'd0),
            with_expect(value_row(-32'sd10), abrf_pkg::RES_EVAL, 32'd50, 16'd0),
            with_expect(value_row(32'd1000), abrf_pkg::RES_ROOT, -32'sd50, 16'd0),
            // root at the high end, just under tolerance
            with_expect(start_row(32'd10, 32'd20), abrf_pkg::RES_EVAL, 32'd10, 16'd0),
            with_expect(value_row(-32'sd1000), abrf_pkg::RES_EVAL, 32'd20, 16'd0),
            with_expect(value_row(32'd65), abrf_pkg::RES_ROOT, 32'd20, 16'd0),
            // restart in the middle of a run
            start_row(32'd0, 32'd1000),
            value_row(-32'sd500),
            with_expect(start_row(32'd5, 32'd3), abrf_pkg::RES_EVAL, 32'd3, 16'd0),
            // no guesses allowed at all
            cfg_row(abrf_pkg::REG_MAX_ITER, 31'd0),
            value_row(-32'sd1000),
            with_expect(value_row(32'd1000), abrf_pkg::RES_NO_CONV, 32'h0, 16'd0),
            // zero tolerance with exact zero values, equal ends in the secant
            cfg_row(abrf_pkg::REG_TOLERANCE, 31'd0),
            cfg_row(abrf_pkg::REG_MAX_ITER, 31'd100),
            with_expect(start_row(32'd0, 32'd100), abrf_pkg::RES_EVAL, 32'd0, 16'd0),
            with_expect(value_row(32'd0), abrf_pkg::RES_EVAL, 32'd100, 16'd0),
            with_expect(value_row(32'd0), abrf_pkg::RES_EVAL, 32'd50, 16'd0),
            with_expect(value_row(32'd0), abrf_pkg::RES_EVAL, 32'd75, 16'd1),
            // limit dropped below the guesses already made
            cfg_row(abrf_pkg::REG_MAX_ITER, 31'd1),
            with_expect(value_row(32'd0), abrf_pkg::RES_NO_CONV, 32'h0, 16'd2)
        };

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                cfg_write(dir_tab[i].reg_sel, dir_tab[i].reg_val);
            end else begin
                send_item(dir_tab[i].kind, dir_tab[i].a, dir_tab[i].b, dir_tab[i].fv, st);
                if (dir_tab[i].typed) begin
                    typed.status  = dir_tab[i].st;
                    typed.point   = dir_tab[i].pt;
                    typed.guesses = dir_tab[i].gu;
                    due_answers[due_answers.size() - 1] = typed;
                end
            end
        end

        // random phases: new register settings and one of four idle patterns each
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin tol_w = 31'd66;          max_w = 16'd100;   end
                1: begin tol_w = 31'h7fff_ffff;   max_w = 16'hffff;  end
                2: begin tol_w = 31'd0;           max_w = 16'd0;     end
                3: begin tol_w = 31'd1;           max_w = 16'd1;     end
                4: begin tol_w = 31'd0;           max_w = 16'd100;   end
                5: begin
                    tol_w = 31'($urandom_range(1, 4096));
                    max_w = 16'($urandom_range(1, 64));
                end
                6: begin
                    tol_w = 31'($urandom);
                    max_w = 16'($urandom_range(0, 300));
                end
                default: begin tol_w = 31'd66;    max_w = 16'hffff;  end
            endcase
            cfg_write(abrf_pkg::REG_TOLERANCE, tol_w);
            cfg_write(abrf_pkg::REG_MAX_ITER, {15'($urandom), max_w});
            case (ph % 4)
                0: begin src_pct = 0;  snk_pct = 0;  end
                1: begin src_pct = 76; snk_pct = 0;  end
                2: begin src_pct = 0;  snk_pct = 76; end
                default: begin src_pct = 16; snk_pct = 16; end
            endcase
            random_phase(212);
        end

        // drain and let the block settle
        in_ch.valid  <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (due_answers.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Sent %0d input beats through a directed table and 8 random phases;",
                 beats_in);
        $display({"%0d results checked: %0d eval, %0d root, %0d not bracketed,",
                  " %0d no convergence, %0d ignored"},
                 checked, tally[0], tally[1], tally[2], tally[3], tally[4]);
        if (due_answers.size() != 0)
            $display("%0d expected results never arrived", due_answers.size());
        if (faults == 0 && due_answers.size() == 0) begin
            $display("[alternating_bracket_root_finder_core] OK");
        end else begin
            $display("%0d mismatching or unexpected results", faults);
            $display("[alternating_bracket_root_finder_core] ERROR");
        end
        $finish;
    end

endmodule
